FILE: rtl/fssg_pkg.sv
// ----------------------------------------------------------------------------
// fssg_pkg
// Shared widths, register indexes and controller/datapath interface types for
// the filled shape span generator.
// ----------------------------------------------------------------------------
package fssg_pkg;

  localparam int COORD_W    = 15;  // coordinate fields on the ports
  localparam int WIDE_W     = 18;  // internal coordinates, never wrap
  localparam int RAD_W      = 6;   // signed radius field
  localparam int WALK_W     = 6;   // walk counters x and y
  localparam int DEC_W      = 12;  // midpoint decision variable
  localparam int MAX_RADIUS = 31;

  localparam int CFG_ADDR_W = 2;
  localparam int S_TDATA_W  = 40;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 48;
  localparam int M_TUSER_W  = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_HEIGHT = 2'd3;

  localparam logic SHAPE_DIAMOND = 1'b0;
  localparam logic SHAPE_CIRCLE  = 1'b1;

  typedef logic signed [WIDE_W-1:0] wide_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture the command beat
    logic step;  // produce the current span and advance the walk
    logic done;  // load the closing done item
    logic err;   // status carried by the done item
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can take an item this cycle
    logic empty;      // clip rectangle has zero width or height
    logic neg;        // command radius is negative
    logic miss;       // bounding box misses the clip rectangle
    logic last_cand;  // current span is the last of the shape
  } dpath_stat_t;

endpackage

FILE: rtl/fssg_ctrl.sv
// ----------------------------------------------------------------------------
// fssg_ctrl
// Command sequencer: accepts a command, checks the trivial cases, steps the
// span walk once per free output slot and closes with the done item.
// ----------------------------------------------------------------------------
module fssg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fssg_pkg::dpath_stat_t stat,
  output fssg_pkg::ctrl_cmd_t  cmd
);
  import fssg_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_TEST, ST_WALK, ST_DONE} state_t;

  state_t state;
  logic   err;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd     = '0;
    cmd.err = err;
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_WALK: cmd.step = stat.out_free;
      ST_DONE: cmd.done = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      err   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_TEST;
        end
        ST_TEST: begin
          // An empty clip rectangle wins over a bad radius.
          if (stat.empty) begin
            err   <= 1'b0;
            state <= ST_DONE;
          end else if (stat.neg) begin
            err   <= 1'b1;
            state <= ST_DONE;
          end else if (stat.miss) begin
            err   <= 1'b0;
            state <= ST_DONE;
          end else begin
            err   <= 1'b0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (stat.out_free && stat.last_cand) state <= ST_DONE;
        end
        ST_DONE: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/fssg_dpath.sv
// ----------------------------------------------------------------------------
// fssg_dpath
// Clip registers, shape walk registers, span clipping and the output register.
// ----------------------------------------------------------------------------
module fssg_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fssg_pkg::ctrl_cmd_t                  cmd,
  output fssg_pkg::dpath_stat_t                stat,
  input  logic                                 cfg_we,
  input  logic [fssg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [fssg_pkg::COORD_W-1:0]         cfg_data,
  input  logic                                 in_opcode,
  input  logic signed [fssg_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [fssg_pkg::COORD_W-1:0]  in_center_y,
  input  logic signed [fssg_pkg::RAD_W-1:0]    in_radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fssg_pkg::COORD_W-1:0]  out_row,
  output logic signed [fssg_pkg::COORD_W-1:0]  out_start,
  output logic signed [fssg_pkg::COORD_W-1:0]  out_end,
  output logic                                 out_span_valid,
  output logic                                 out_status,
  output logic                                 out_last
);
  import fssg_pkg::*;

  typedef enum logic [1:0] {PH_ROW_UP, PH_ROW_DOWN, PH_CAP_UP, PH_CAP_DOWN} phase_t;

  function automatic wide_t sx(input logic [COORD_W-1:0] v);
    sx = $signed({{(WIDE_W-COORD_W){v[COORD_W-1]}}, v});
  endfunction

  function automatic wide_t zx(input logic [WALK_W-1:0] v);
    zx = $signed({{(WIDE_W-WALK_W){1'b0}}, v});
  endfunction

  function automatic logic signed [DEC_W-1:0] dx(input logic [WALK_W-1:0] v);
    dx = $signed({{(DEC_W-WALK_W){1'b0}}, v});
  endfunction

  // Clip rectangle.
  logic [COORD_W-1:0] clip_left, clip_top, clip_width, clip_height;
  wide_t              left_w, top_w, clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= '0;
      clip_height <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CLIP_LEFT:   clip_left   <= cfg_data;
        REG_CLIP_TOP:    clip_top    <= cfg_data;
        REG_CLIP_WIDTH:  clip_width  <= cfg_data;
        REG_CLIP_HEIGHT: clip_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign left_w = sx(clip_left);
  assign top_w  = sx(clip_top);

  // Inclusive far edges of the clip rectangle.
  assign clip_right  = left_w + $signed({{(WIDE_W-COORD_W){1'b0}}, clip_width}) - wide_t'(1);
  assign clip_bottom = top_w + $signed({{(WIDE_W-COORD_W){1'b0}}, clip_height}) - wide_t'(1);

  // Command and walk registers.
  logic                     shape;
  wide_t                    xc, yc;
  logic [WALK_W-2:0]        rad;
  logic                     neg;
  logic [WALK_W-1:0]        x, y;
  logic signed [DEC_W-1:0]  dec;
  phase_t                   ph, ph_next;

  logic [WALK_W-2:0] rad_in;
  always_comb begin
    if (in_radius[RAD_W-1]) begin
      rad_in = '0;
    end else if (in_radius[RAD_W-2:0] > (WALK_W-1)'(MAX_RADIUS)) begin
      rad_in = (WALK_W-1)'(MAX_RADIUS);
    end else begin
      rad_in = in_radius[RAD_W-2:0];
    end
  end

  // Span of the current phase.
  logic              use_cap, row_up;
  logic [WALK_W-1:0] hw, off;
  wide_t             row, xs, xe, cl_start, cl_end;
  logic              visible;

  always_comb begin
    use_cap = (ph == PH_CAP_UP) || (ph == PH_CAP_DOWN);
    row_up  = (ph == PH_ROW_UP) || (ph == PH_CAP_UP);
    hw      = use_cap ? x : y;
    off     = use_cap ? y : x;
    row     = row_up ? (yc - zx(off)) : (yc + zx(off));
    xs      = xc - zx(hw);
    xe      = xc + zx(hw);
    visible = !(xe < left_w || xs > clip_right || row < top_w || row > clip_bottom);
    cl_start = (xs < left_w) ? left_w : xs;
    cl_end   = (xe > clip_right) ? clip_right : xe;
  end

  // Walk sequencing.
  logic cond, cap_ok, end_iter, finish;

  always_comb begin
    cond     = !dec[DEC_W-1];
    cap_ok   = (shape == SHAPE_CIRCLE) && cond && (y != x);
    end_iter = 1'b0;
    ph_next  = PH_ROW_UP;
    case (ph)
      PH_ROW_UP: begin
        if (x != '0) begin
          ph_next = PH_ROW_DOWN;
        end else if (cap_ok) begin
          ph_next = PH_CAP_UP;
        end else begin
          end_iter = 1'b1;
        end
      end
      PH_ROW_DOWN: begin
        if (cap_ok) begin
          ph_next = PH_CAP_UP;
        end else begin
          end_iter = 1'b1;
        end
      end
      PH_CAP_UP:   ph_next = PH_CAP_DOWN;
      PH_CAP_DOWN: end_iter = 1'b1;
      default:     end_iter = 1'b1;
    endcase
    // The circle ends once the advanced x passes the (possibly lowered) y.
    if (shape == SHAPE_CIRCLE) begin
      finish = ({1'b0, x} + (WALK_W+1)'(1) + (WALK_W+1)'(cond)) > {1'b0, y};
    end else begin
      finish = (y == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shape <= in_opcode;
      xc    <= sx(in_center_x);
      yc    <= sx(in_center_y);
      rad   <= rad_in;
      neg   <= in_radius[RAD_W-1];
      x     <= '0;
      y     <= {1'b0, rad_in};
      dec   <= DEC_W'(1) - $signed({{(DEC_W-WALK_W+1){1'b0}}, rad_in});
      ph    <= PH_ROW_UP;
    end else if (cmd.step) begin
      if (end_iter) begin
        x  <= x + WALK_W'(1);
        ph <= PH_ROW_UP;
        if (shape == SHAPE_CIRCLE) begin
          if (cond) begin
            y   <= y - WALK_W'(1);
            dec <= dec + (dx(x) - dx(y)) + (dx(x) - dx(y)) + DEC_W'(7);
          end else begin
            dec <= dec + dx(x) + dx(x) + DEC_W'(3);
          end
        end else begin
          y <= y - WALK_W'(1);
        end
      end else begin
        ph <= ph_next;
      end
    end
  end

  // Bounding box test for the command held in the registers.
  wide_t rad_w;
  assign rad_w = $signed({{(WIDE_W-WALK_W+1){1'b0}}, rad});

  // Output register.
  logic  o_valid, o_span_valid, o_status, o_last;
  wide_t o_row, o_start, o_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if ((cmd.step && visible) || cmd.done) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      o_row        <= '0;
      o_start      <= '0;
      o_end        <= '0;
      o_span_valid <= 1'b0;
      o_status     <= cmd.err;
      o_last       <= 1'b1;
    end else if (cmd.step && visible) begin
      o_row        <= row;
      o_start      <= cl_start;
      o_end        <= cl_end;
      o_span_valid <= 1'b1;
      o_status     <= 1'b0;
      o_last       <= 1'b0;
    end
  end

  always_comb begin
    stat.out_free  = !o_valid || out_ready;
    stat.empty     = (clip_width == '0) || (clip_height == '0);
    stat.neg       = neg;
    stat.miss      = (xc + rad_w < left_w) || (xc - rad_w > clip_right) ||
                     (yc + rad_w < top_w) || (yc - rad_w > clip_bottom);
    stat.last_cand = end_iter && finish;
  end

  assign out_valid      = o_valid;
  assign out_row        = o_row[COORD_W-1:0];
  assign out_start      = o_start[COORD_W-1:0];
  assign out_end        = o_end[COORD_W-1:0];
  assign out_span_valid = o_span_valid;
  assign out_status     = o_status;
  assign out_last       = o_last;

`ifndef SYNTHESIS
  // A delivered span always lies inside the clip rectangle and is not reversed.
  assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_span_valid) |->
      (o_start >= left_w && o_end <= clip_right && o_start <= o_end &&
       o_row >= top_w && o_row <= clip_bottom))
    else $error("span outside clip rectangle");

  // The circle walk only runs while x has not passed y.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.step && shape == SHAPE_CIRCLE) |-> (x <= y))
    else $error("circle walk overran");

  // Diamond rows trade half width for distance from the center.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.step && shape == SHAPE_DIAMOND) |-> ((x + y) == {1'b0, rad}))
    else $error("diamond walk out of step");
`endif

endmodule

FILE: rtl/filled_shape_span_generator.sv
// ----------------------------------------------------------------------------
// filled_shape_span_generator
// Emits the clipped horizontal spans of a filled diamond or circle.
// ----------------------------------------------------------------------------
// Each beat on the s_ channel is one command: shape in s_tuser, center and
// radius in s_tdata. The m_ channel returns one beat per visible span, then a
// done beat with m_tlast high whose status bit flags a negative radius (an
// empty clip rectangle clears it). The clip rectangle is set through the
// cfg channel (index 0 left, 1 top, 2 width, 3 height); the user must write
// it only while no command is in flight, which the block does not enforce,
// as cfg_ready is always high. A command is taken one at a time: s_tready is
// high only between commands. After acceptance a test state checks the clip
// and radius cases, then the walk produces one candidate span per cycle
// while the output stage is free. A registered output stage holds each beat;
// when m_tready is low the walk pauses and resumes without loss. Reset clears
// the clip rectangle to zero, empties the output stage and returns the
// sequencer to waiting for a command.
// ----------------------------------------------------------------------------
module filled_shape_span_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fssg_pkg::S_TDATA_W-1:0]    s_tdata,   // center_x, center_y, radius
  input  logic [fssg_pkg::S_TUSER_W-1:0]    s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fssg_pkg::M_TDATA_W-1:0]    m_tdata,   // span_row, span_start, span_end
  output logic [fssg_pkg::M_TUSER_W-1:0]    m_tuser,   // span_valid, status
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fssg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fssg_pkg::COORD_W-1:0]      cfg_data
);
  import fssg_pkg::*;

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  logic signed [COORD_W-1:0] span_row, span_start, span_end;
  logic                      span_valid, status;

  assign cfg_ready = 1'b1;

  fssg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fssg_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .in_opcode      (s_tuser[0]),
    .in_center_x    (s_tdata[14:0]),
    .in_center_y    (s_tdata[29:15]),
    .in_radius      (s_tdata[35:30]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_row        (span_row),
    .out_start      (span_start),
    .out_end        (span_end),
    .out_span_valid (span_valid),
    .out_status     (status),
    .out_last       (m_tlast)
  );

  assign m_tdata = {{(M_TDATA_W-3*COORD_W){1'b0}}, span_end, span_start, span_row};
  assign m_tuser = {status, span_valid};

endmodule
